// File: hw/rtl/tpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, codes and constants for the typed packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = 6;
  localparam int KIND_W  = 2;
  localparam int CFG_A_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] TYPE_CMD  = 8'h03;
  localparam logic [BYTE_W-1:0] TYPE_EMG  = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_IMU  = 8'h02;

  localparam logic [LEN_W-1:0] CMD_LEN_RST = 7'd1;
  localparam logic [LEN_W-1:0] EMG_LEN_RST = 7'd27;
  localparam logic [LEN_W-1:0] IMU_LEN_RST = 7'd48;

  localparam logic [CFG_A_W-1:0] REG_CMD_LEN = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_EMG_LEN = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_IMU_LEN = 2'd2;

  localparam logic [STAT_W-1:0] ST_PARSING = 3'd0;
  localparam logic [STAT_W-1:0] ST_ERROR   = 3'd1;
  localparam logic [STAT_W-1:0] ST_IMU     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMG     = 3'd3;
  localparam logic [STAT_W-1:0] ST_COMMAND = 3'd4;

  localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMG     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IMU     = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  payload_index;
    logic [KIND_W-1:0] payload_kind;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/typed_packet_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// typed_packet_deframer_top
// Hunts for FF FF sync, decodes the type byte, forwards payload bytes with
// index and kind, and checks the additive checksum at the end of each frame.
// ----------------------------------------------------------------------------
// One received byte is accepted per clock cycle while in_stall is low and yields
// exactly one result word, registered in the output queue. Frame state is
// updated at acceptance by a single pass of logic; results go into a
// two-word output queue, so input keeps flowing for one more word while the
// downstream side stalls, and in_stall rises only when both entries are full.
// Length registers take effect on the next byte and should be written only
// while no word is in flight.
module typed_packet_deframer_top #(
  parameter int MAX_PAYLOAD = tpd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [tpd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [tpd_pkg::STAT_W-1:0]  out_status,
  output logic                        out_payload_valid,
  output logic [tpd_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic [tpd_pkg::IDX_W-1:0]   out_payload_index,
  output logic [tpd_pkg::KIND_W-1:0]  out_payload_kind,
  input  wire                         cfg_we,
  input  wire  [tpd_pkg::CFG_A_W-1:0] cfg_index,
  input  wire  [tpd_pkg::LEN_W-1:0]   cfg_data
);
  import tpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PAYLOAD);
  localparam logic [CMP_W-1:0] ONE_LEN = CMP_W'(1);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_TYPE  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SUM   = 3'd4;

  logic [LEN_W-1:0]  cmd_len_r, emg_len_r, imu_len_r;
  logic [2:0]        phase_r, phase_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;

  result_t           res;
  result_t           fifo_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        fill_r;
  logic              push, pop;

  logic [LEN_W-1:0]  sel_len;
  logic [CMP_W-1:0]  raw_len, eff_len, count_ext, count_inc;

  // ---- config registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_len_r <= CMD_LEN_RST;
      emg_len_r <= EMG_LEN_RST;
      imu_len_r <= IMU_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_CMD_LEN) cmd_len_r <= cfg_data;
      if (cfg_index == REG_EMG_LEN) emg_len_r <= cfg_data;
      if (cfg_index == REG_IMU_LEN) imu_len_r <= cfg_data;
    end
  end

  // ---- effective length for current kind ----
  always_comb begin
    priority if (kind_r == KIND_COMMAND) sel_len = cmd_len_r;
    else if (kind_r == KIND_EMG)         sel_len = emg_len_r;
    else                                 sel_len = imu_len_r;
    raw_len = CMP_W'(sel_len);
    priority if (raw_len == '0)     eff_len = ONE_LEN;
    else if (raw_len > MAX_LEN)     eff_len = MAX_LEN;
    else                            eff_len = raw_len;
    count_ext = CMP_W'(count_r);
    count_inc = count_ext + ONE_LEN;
  end

  // ---- frame parser ----
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    res       = '0;
    res.status = ST_PARSING;
    unique case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
      end
      PH_TYPE: begin
        phase_nxt = PH_DATA;
        count_nxt = '0;
        sum_nxt   = '0;
        priority if (in_rx_byte == TYPE_CMD) kind_nxt = KIND_COMMAND;
        else if (in_rx_byte == TYPE_EMG)     kind_nxt = KIND_EMG;
        else if (in_rx_byte == TYPE_IMU)     kind_nxt = KIND_IMU;
        else begin
          phase_nxt  = PH_HUNT;
          count_nxt  = count_r;
          sum_nxt    = sum_r;
          res.status = ST_ERROR;
        end
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_rx_byte;
        res.payload_index = count_ext[IDX_W-1:0];
        res.payload_kind  = kind_r;
        count_nxt = count_inc[CNT_W-1:0];
        sum_nxt   = sum_r + in_rx_byte;
        if (count_inc >= eff_len) phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        phase_nxt = PH_HUNT;
        if (in_rx_byte == sum_r) begin
          priority if (kind_r == KIND_IMU) res.status = ST_IMU;
          else if (kind_r == KIND_EMG)     res.status = ST_EMG;
          else                             res.status = ST_COMMAND;
        end else begin
          res.status = ST_ERROR;
        end
      end
      default: begin
        phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  assign push     = in_valid & ~in_stall;
  assign pop      = out_valid & ~out_stall;
  assign in_stall = fill_r[1];
  assign out_valid = (fill_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      kind_r   <= KIND_COMMAND;
      count_r  <= '0;
      sum_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        count_r  <= count_nxt;
        sum_r    <= sum_nxt;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // result queue, no reset on payload
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= res;
  end

  assign out_status        = fifo_r[rd_ptr_r].status;
  assign out_payload_valid = fifo_r[rd_ptr_r].payload_valid;
  assign out_payload_byte  = fifo_r[rd_ptr_r].payload_byte;
  assign out_payload_index = fifo_r[rd_ptr_r].payload_index;
  assign out_payload_kind  = fifo_r[rd_ptr_r].payload_kind;

endmodule
`default_nettype wire

// File: hw/rtl/tpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_checker
// Port-level checks for the typed packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module tpd_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire [tpd_pkg::STAT_W-1:0]  out_status,
  input wire                        out_payload_valid,
  input wire [tpd_pkg::BYTE_W-1:0]  out_payload_byte,
  input wire [tpd_pkg::IDX_W-1:0]   out_payload_index,
  input wire [tpd_pkg::KIND_W-1:0]  out_payload_kind
);
  import tpd_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_payload_valid) && $stable(out_payload_byte)
      && $stable(out_payload_index) && $stable(out_payload_kind))
    else $error("output word changed while stalled");

  a_payload_parsing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == ST_PARSING)
    else $error("payload word carries a frame status");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |->
      out_payload_byte == '0 && out_payload_index == '0
      && out_payload_kind == KIND_COMMAND)
    else $error("payload fields set on non-payload word");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |->
      out_payload_kind == KIND_COMMAND || out_payload_kind == KIND_EMG
      || out_payload_kind == KIND_IMU)
    else $error("illegal payload kind");

endmodule

bind typed_packet_deframer_top tpd_checker u_tpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_payload_valid (out_payload_valid),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_payload_kind  (out_payload_kind)
);
`default_nettype wire
